/* design/ttdt_pkg.sv */
// Shared types, constants and the divider-point table of the thermistor decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ttdt_pkg;

  localparam int TABLE_POINTS  = 32;
  localparam int STORED_POINTS = 32;

  localparam int SAMPLE_W   = 12;
  localparam int DPS_W      = 3;
  localparam int BASE_W     = 8;
  localparam int IDX_W      = $clog2(TABLE_POINTS);
  localparam int LAST_IDX   = TABLE_POINTS - 1;
  localparam int QUO_W      = 7;                    // fraction in percent stays below 128
  localparam int NUM_W      = SAMPLE_W + QUO_W;
  localparam int STEP_MAX   = (IDX_W > QUO_W) ? IDX_W : QUO_W;
  localparam int CNT_W      = $clog2(STEP_MAX);
  localparam int PROD_W     = IDX_W + DPS_W;
  localparam int TEMP_W     = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
  localparam int TEMP_MAX   = 255;
  localparam int TENS_W     = 5;
  localparam int UNITS_W    = 4;
  localparam int TENTHS_W   = 4;
  localparam int DIGIT_MAX  = 9;
  localparam int FRAC_SCALE = 100;
  localparam int ROUND_HALF = 5;
  localparam int RECIP_10   = 205;                  // 205 / 2048 ~ 1/10, exact below 1024
  localparam int RECIP_SH   = 11;
  localparam int DIG_MUL_W  = 16;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [DPS_W-1:0]  DPS_RESET  = 3'd1;
  localparam logic [BASE_W-1:0] BASE_RESET = 8'd10;

  // Fixed digits for a sample above the table and for the last segment
  localparam logic [TENS_W-1:0]  TOP_TENS   = 5'd1;
  localparam logic [UNITS_W-1:0] TOP_UNITS  = 4'd0;
  localparam logic [TENS_W-1:0]  LAST_TENS  = 5'd4;
  localparam logic [UNITS_W-1:0] LAST_UNITS = 4'd1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEGREES_PER_STEP = 1'b0,
    CFG_BASE_TEMPERATURE = 1'b1
  } ttdt_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCALE,
    ST_DIVIDE,
    ST_EMIT
  } ttdt_state_t;

  typedef struct packed {
    logic             load;    // capture a new sample
    logic             search;  // one bit of the segment search
    logic             scale;   // temperature, span and numerator
    logic             divide;  // one quotient bit
    logic             emit;    // fill the output register
    logic [CNT_W-1:0] step;    // bit position of the current search or divide step
  } ttdt_cmd_t;

  localparam logic [SAMPLE_W-1:0] DIVIDER_POINTS [STORED_POINTS] = '{
    12'd4095, 12'd4061, 12'd3994, 12'd3926, 12'd3858, 12'd3790, 12'd3721, 12'd3653,
    12'd3584, 12'd3515, 12'd3445, 12'd3376, 12'd3308, 12'd3239, 12'd3170, 12'd3102,
    12'd3035, 12'd2967, 12'd2901, 12'd2834, 12'd2769, 12'd2704, 12'd2640, 12'd2576,
    12'd2514, 12'd2452, 12'd2391, 12'd2331, 12'd2272, 12'd2214, 12'd2157, 12'd2101
  };

  // Points past the stored ones repeat the last stored value
  function automatic logic [SAMPLE_W-1:0] point_at(input logic [IDX_W-1:0] idx);
    int i;
    i = int'(idx);
    if (i > STORED_POINTS - 1) i = STORED_POINTS - 1;
    return DIVIDER_POINTS[i];
  endfunction

endpackage

/* design/thermistor_table_to_decimal_temp_top.sv */
// Top level of the thermistor sample to decimal temperature decoder.
// Instantiates ttdt_ctrl and ttdt_datapath; depends on ttdt_pkg.
`timescale 1ns / 1ps

//  channel | direction | word layout (lsb first)                 | accepted when
//  in_     | slave     | adc_sample[11:0], zero pad to 16        | in_tvalid & in_tready
//  out_    | master    | tens[4:0], units[8:5], tenths[12:9]     | out_tvalid & out_tready
//  cfg_    | write     | idx 0 degrees_per_step, 1 base_temp     | cfg_we
//
// One word at a time: accept, IDX_W search steps (5 for 32 table points) against the
// constant point table, a scaling step, QUO_W (7) restoring divide steps and an emit
// step. The search is bit-serial and the divider produces one quotient bit a step.
// The output register frees the input side: a new word is taken while a result waits;
// only the emit cycle stalls on a full output register.
// Synchronous active-low reset clears state and loads degrees_per_step 1, base 10.

module thermistor_table_to_decimal_temp_top import ttdt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // slave side
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] adc_sample, rest unused
  // master side
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [4:0] tens, [8:5] units, [12:9] tenths, 0 pad
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  ttdt_cmd_t           cmd;
  logic [TENS_W-1:0]   tens;
  logic [UNITS_W-1:0]  units;
  logic [TENTHS_W-1:0] tenths;

  // sequencer: handshakes and step count
  ttdt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // arithmetic and the output register
  ttdt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .out_tens   (tens),
    .out_units  (units),
    .out_tenths (tenths)
  );

  // pack fields lowest first, pad with zeros
  assign out_tdata = OUT_TDATA_W'({tenths, units, tens});

endmodule

/* design/ttdt_ctrl.sv */
// Sequencer of the thermistor decoder: state, step counter and output valid flag.
// Depends on ttdt_pkg; drives the datapath through ttdt_cmd_t.
`timescale 1ns / 1ps

module ttdt_ctrl import ttdt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output ttdt_cmd_t cmd
);

  ttdt_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.step  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_W'(IDX_W - 1);
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (cnt_r == '0) state_nxt = ST_SCALE;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        cnt_nxt   = CNT_W'(QUO_W - 1);
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        if (cnt_r == '0) state_nxt = ST_EMIT;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_EMIT: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_SEARCH && cnt_r == CNT_W'(IDX_W - 1))
    else $error("accepted word did not start the search");

  a_divide_ends_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVIDE && cnt_r == '0 |=> state_r == ST_EMIT)
    else $error("division did not end in emit");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && state_r == ST_IDLE)
    else $error("emit did not present a result");

endmodule

/* design/ttdt_datapath.sv */
// Datapath of the thermistor decoder: config registers, segment search, scaling,
// restoring divider and digit split into the output register. Depends on ttdt_pkg.
`timescale 1ns / 1ps

module ttdt_datapath import ttdt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ttdt_cmd_t             cmd,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic [TENS_W-1:0]     out_tens,
  output logic [UNITS_W-1:0]    out_units,
  output logic [TENTHS_W-1:0]   out_tenths
);

  logic [DPS_W-1:0]    dps_r;
  logic [BASE_W-1:0]   base_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [IDX_W-1:0]    k_r;
  logic                top_r, last_r, frac_ok_r;
  logic [BASE_W-1:0]   temp_r;
  logic [SAMPLE_W-1:0] span_r;
  logic [NUM_W-1:0]    rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [TENS_W-1:0]   tens_r;
  logic [UNITS_W-1:0]  units_r;
  logic [TENTHS_W-1:0] tenths_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dps_r  <= DPS_RESET;
      base_r <= BASE_RESET;
    end else if (cfg_we) begin
      unique case (ttdt_cfg_idx_t'(cfg_addr))
        CFG_DEGREES_PER_STEP: dps_r  <= cfg_wdata[DPS_W-1:0];
        CFG_BASE_TEMPERATURE: base_r <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // search: grow the index of the last point above the sample, one bit a step
  logic [IDX_W-1:0] trial_idx;
  logic             trial_take;
  assign trial_idx  = k_r | (IDX_W'(1) << cmd.step);
  assign trial_take = (trial_idx <= IDX_W'(LAST_IDX)) && (point_at(trial_idx) > sample_r);

  // scale
  logic                is_last;
  logic [IDX_W-1:0]    seg;
  logic [SAMPLE_W-1:0] hi, lo;
  logic [TEMP_W-1:0]   temp_wide;
  logic [NUM_W-1:0]    numer;
  assign is_last   = k_r >= IDX_W'(LAST_IDX - 1);
  assign seg       = is_last ? IDX_W'(LAST_IDX) : k_r + 1'b1;
  assign hi        = point_at(seg - 1'b1);
  assign lo        = point_at(seg);
  assign temp_wide = TEMP_W'(seg) * TEMP_W'(dps_r) + TEMP_W'(base_r);
  assign numer     = NUM_W'(sample_r - lo) * NUM_W'(FRAC_SCALE);

  // divide
  logic [NUM_W-1:0] div_trial;
  assign div_trial = NUM_W'(span_r) << cmd.step;

  // digits
  logic [DIG_MUL_W-1:0] tens_prod, tenths_prod;
  logic [TENS_W-1:0]    tens_d;
  logic [UNITS_W-1:0]   units_d;
  logic [BASE_W-1:0]    rounded;
  logic [TENTHS_W-1:0]  tenths_q, tenths_d;
  assign tens_prod   = DIG_MUL_W'(temp_r) * DIG_MUL_W'(RECIP_10);
  assign tens_d      = TENS_W'(tens_prod >> RECIP_SH);
  assign units_d     = UNITS_W'(temp_r - BASE_W'(tens_d) * BASE_W'(10));
  assign rounded     = BASE_W'(quo_r) + BASE_W'(ROUND_HALF);
  assign tenths_prod = DIG_MUL_W'(rounded) * DIG_MUL_W'(RECIP_10);
  assign tenths_q    = TENTHS_W'(tenths_prod >> RECIP_SH);
  assign tenths_d    = (tenths_q > TENTHS_W'(DIGIT_MAX)) ? TENTHS_W'(DIGIT_MAX) : tenths_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      k_r      <= '0;
      top_r    <= in_sample >= point_at('0);
    end
    if (cmd.search && trial_take) k_r <= trial_idx;
    if (cmd.scale) begin
      last_r    <= is_last;
      temp_r    <= (temp_wide > TEMP_W'(TEMP_MAX)) ? BASE_W'(TEMP_MAX) : temp_wide[BASE_W-1:0];
      span_r    <= hi - lo;
      frac_ok_r <= (hi > lo) && (sample_r >= lo);
      rem_r     <= numer;
      quo_r     <= '0;
    end
    if (cmd.divide && rem_r >= div_trial) begin
      rem_r <= rem_r - div_trial;
      quo_r <= quo_r | (QUO_W'(1) << cmd.step);
    end
    if (cmd.emit) begin
      priority if (top_r) begin
        tens_r   <= TOP_TENS;
        units_r  <= TOP_UNITS;
        tenths_r <= '0;
      end else if (last_r) begin
        tens_r   <= LAST_TENS;
        units_r  <= LAST_UNITS;
        tenths_r <= '0;
      end else begin
        tens_r   <= tens_d;
        units_r  <= units_d;
        tenths_r <= frac_ok_r ? tenths_d : '0;
      end
    end
  end

  assign out_tens   = tens_r;
  assign out_units  = units_r;
  assign out_tenths = tenths_r;

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search && trial_take |-> trial_idx <= IDX_W'(LAST_IDX))
    else $error("search stepped past the last table point");

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> units_r <= UNITS_W'(DIGIT_MAX) && tenths_r <= TENTHS_W'(DIGIT_MAX))
    else $error("units or tenths digit above nine");

  a_tens_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> tens_r <= TENS_W'(TEMP_MAX / 10))
    else $error("tens digit beyond saturated temperature");

endmodule
